// ----- design/fdaa_pkg.sv -----
// ----------------------------------------------------------------------------
// fdaa_pkg
// Shared widths, codes and the queue word type for the focus distance block.
// ----------------------------------------------------------------------------
`default_nettype none

package fdaa_pkg;

  localparam int COORD_W   = 32;
  localparam int CMD_W     = 2;
  localparam int CFG_IDX_W = 2;
  localparam int DIFF_W    = COORD_W + 1;
  localparam int PROD_W    = 2 * DIFF_W;
  localparam int CROSS_W   = PROD_W - 1;
  localparam int LO_W      = DIFF_W;
  localparam int HI_W      = CROSS_W - LO_W;
  localparam int SQ_W      = 2 * CROSS_W;
  localparam int NUM_W     = SQ_W + 2;
  localparam int DEN_W     = PROD_W;
  localparam int QUO_W     = 2 * COORD_W;
  localparam int ROOT_W    = COORD_W;
  localparam int REM_W     = ROOT_W + 2;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W    = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W    = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [CMD_W-1:0] {
    CMD_CYLINDER = 2'd0,
    CMD_CONE     = 2'd1,
    CMD_OTHER    = 2'd2
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FOCUS_X = 2'd0,
    REG_FOCUS_Y = 2'd1,
    REG_FOCUS_Z = 2'd2
  } cfg_idx_e;

  typedef logic signed [DIFF_W-1:0] diff_t;

  typedef struct packed {
    logic  has;
    logic  cyl;
    diff_t dx;
    diff_t dy;
    diff_t dz;
    diff_t vx;
    diff_t vy;
    diff_t vz;
  } item_t;

endpackage

`default_nettype wire

// ----- design/fdaa_front.sv -----
// ----------------------------------------------------------------------------
// fdaa_front
// Holds the focus registers, classifies each command and forms the offset
// vectors from the first point to the focus and to the second point.
// ----------------------------------------------------------------------------
`default_nettype none

module fdaa_front import fdaa_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [CFG_IDX_W-1:0]       cfg_index_i,
  input  logic signed [COORD_W-1:0]  cfg_data_i,
  input  logic [CMD_W-1:0]           cmd_i,
  input  logic signed [COORD_W-1:0]  ax_i,
  input  logic signed [COORD_W-1:0]  ay_i,
  input  logic signed [COORD_W-1:0]  az_i,
  input  logic signed [COORD_W-1:0]  bx_i,
  input  logic signed [COORD_W-1:0]  by_i,
  input  logic signed [COORD_W-1:0]  bz_i,
  output item_t                      item_o
);

  logic signed [COORD_W-1:0] fx_q, fy_q, fz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fx_q <= '0;
      fy_q <= '0;
      fz_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_FOCUS_X: fx_q <= cfg_data_i;
        REG_FOCUS_Y: fy_q <= cfg_data_i;
        REG_FOCUS_Z: fz_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    item_o.has = (cmd_i == CMD_CYLINDER) || (cmd_i == CMD_CONE);
    item_o.cyl = (cmd_i == CMD_CYLINDER);
    item_o.dx  = diff_t'(fx_q) - diff_t'(ax_i);
    item_o.dy  = diff_t'(fy_q) - diff_t'(ay_i);
    item_o.dz  = diff_t'(fz_q) - diff_t'(az_i);
    item_o.vx  = diff_t'(bx_i) - diff_t'(ax_i);
    item_o.vy  = diff_t'(by_i) - diff_t'(ay_i);
    item_o.vz  = diff_t'(bz_i) - diff_t'(az_i);
  end

endmodule

`default_nettype wire

// ----- design/fdaa_queue.sv -----
// ----------------------------------------------------------------------------
// fdaa_queue
// Short first-in first-out queue that decouples the front from the back.
// ----------------------------------------------------------------------------
`default_nettype none

module fdaa_queue import fdaa_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t data_i,
  input  logic  pop_i,
  output item_t data_o,
  output logic  full_o,
  output logic  empty_o
);

  item_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0]  count_q;
  logic               do_push, do_pop;

  assign full_o  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- design/fdaa_calc.sv -----
// ----------------------------------------------------------------------------
// fdaa_calc
// Pipeline that forms the squared cross product and squared axis length,
// or the squared apex distance, as a numerator and denominator pair.
// ----------------------------------------------------------------------------
`default_nettype none

module fdaa_calc import fdaa_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  item_t             item_i,
  output logic              valid_o,
  output logic              has_o,
  output logic [NUM_W-1:0]  num_o,
  output logic [DEN_W-1:0]  den_o
);

  // Stage 1: products.
  logic                      s1_vld_q, s1_has_q, s1_cyl_q;
  logic signed [PROD_W-1:0]  s1_pa_q [3];
  logic signed [PROD_W-1:0]  s1_pb_q [3];
  logic signed [PROD_W-1:0]  s1_vv_q [3];
  logic signed [PROD_W-1:0]  s1_dd_q [3];
  // Stage 2: cross magnitudes and sums of squares.
  logic                      s2_vld_q, s2_has_q, s2_cyl_q;
  logic [CROSS_W-1:0]        s2_c_q [3];
  logic [DEN_W-1:0]          s2_m_q, s2_nd_q;
  logic [CROSS_W-1:0]        s2_c_d [3];
  // Stage 3: partial products of the cross squares.
  logic                      s3_vld_q, s3_has_q, s3_cyl_q;
  logic [2*HI_W-1:0]         s3_hh_q [3];
  logic [HI_W+LO_W-1:0]      s3_hl_q [3];
  logic [2*LO_W-1:0]         s3_ll_q [3];
  logic [DEN_W-1:0]          s3_m_q, s3_nd_q;
  // Stage 4: cross squares.
  logic                      s4_vld_q, s4_has_q, s4_cyl_q;
  logic [SQ_W-1:0]           s4_sq_q [3];
  logic [DEN_W-1:0]          s4_m_q, s4_nd_q;
  // Stage 5: selected ratio.
  logic                      s5_vld_q, s5_has_q;
  logic [NUM_W-1:0]          s5_num_q;
  logic [DEN_W-1:0]          s5_den_q;

  always_comb begin
    logic signed [PROD_W:0] diff;
    for (int i = 0; i < 3; i++) begin
      diff = (PROD_W+1)'(s1_pa_q[i]) - (PROD_W+1)'(s1_pb_q[i]);
      if (diff < 0) begin
        diff = -diff;
      end
      s2_c_d[i] = diff[CROSS_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
      s5_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= valid_i;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
      s4_vld_q <= s3_vld_q;
      s5_vld_q <= s4_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_has_q   <= item_i.has;
    s1_cyl_q   <= item_i.cyl;
    s1_pa_q[0] <= item_i.dy * item_i.vz;
    s1_pb_q[0] <= item_i.dz * item_i.vy;
    s1_pa_q[1] <= item_i.dz * item_i.vx;
    s1_pb_q[1] <= item_i.dx * item_i.vz;
    s1_pa_q[2] <= item_i.dx * item_i.vy;
    s1_pb_q[2] <= item_i.dy * item_i.vx;
    s1_vv_q[0] <= item_i.vx * item_i.vx;
    s1_vv_q[1] <= item_i.vy * item_i.vy;
    s1_vv_q[2] <= item_i.vz * item_i.vz;
    s1_dd_q[0] <= item_i.dx * item_i.dx;
    s1_dd_q[1] <= item_i.dy * item_i.dy;
    s1_dd_q[2] <= item_i.dz * item_i.dz;

    s2_has_q <= s1_has_q;
    s2_cyl_q <= s1_cyl_q;
    s2_c_q   <= s2_c_d;
    s2_m_q   <= $unsigned(s1_vv_q[0]) + $unsigned(s1_vv_q[1]) + $unsigned(s1_vv_q[2]);
    s2_nd_q  <= $unsigned(s1_dd_q[0]) + $unsigned(s1_dd_q[1]) + $unsigned(s1_dd_q[2]);

    s3_has_q <= s2_has_q;
    s3_cyl_q <= s2_cyl_q && (s2_m_q != '0);
    s3_m_q   <= s2_m_q;
    s3_nd_q  <= s2_nd_q;
    for (int i = 0; i < 3; i++) begin
      s3_hh_q[i] <= (2*HI_W)'(s2_c_q[i][CROSS_W-1:LO_W]) * (2*HI_W)'(s2_c_q[i][CROSS_W-1:LO_W]);
      s3_hl_q[i] <= (HI_W+LO_W)'(s2_c_q[i][CROSS_W-1:LO_W]) * (HI_W+LO_W)'(s2_c_q[i][LO_W-1:0]);
      s3_ll_q[i] <= (2*LO_W)'(s2_c_q[i][LO_W-1:0]) * (2*LO_W)'(s2_c_q[i][LO_W-1:0]);
    end

    s4_has_q <= s3_has_q;
    s4_cyl_q <= s3_cyl_q;
    s4_m_q   <= s3_m_q;
    s4_nd_q  <= s3_nd_q;
    for (int i = 0; i < 3; i++) begin
      s4_sq_q[i] <= (SQ_W'(s3_hh_q[i]) << (2*LO_W)) + (SQ_W'(s3_hl_q[i]) << (LO_W+1))
                  + SQ_W'(s3_ll_q[i]);
    end

    s5_has_q <= s4_has_q;
    if (s4_cyl_q) begin
      s5_num_q <= NUM_W'(s4_sq_q[0]) + NUM_W'(s4_sq_q[1]) + NUM_W'(s4_sq_q[2]);
      s5_den_q <= s4_m_q;
    end else begin
      s5_num_q <= NUM_W'(s4_nd_q);
      s5_den_q <= DEN_W'(1);
    end
  end

  assign valid_o = s5_vld_q;
  assign has_o   = s5_has_q;
  assign num_o   = s5_num_q;
  assign den_o   = s5_den_q;

endmodule

`default_nettype wire

// ----- design/fdaa_root.sv -----
// ----------------------------------------------------------------------------
// fdaa_root
// Pipelined restoring divider and square root that turn the ratio into the
// truncated, saturated distance, followed by the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module fdaa_root import fdaa_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  logic               has_i,
  input  logic [NUM_W-1:0]   num_i,
  input  logic [DEN_W-1:0]   den_i,
  output logic               done_o,
  output logic               has_o,
  output logic [ROOT_W-1:0]  dist_o
);

  logic                dv_vld_q [QUO_W+1];
  logic                dv_has_q [QUO_W+1];
  logic                dv_sat_q [QUO_W+1];
  logic [DEN_W-1:0]    dv_rem_q [QUO_W+1];
  logic [DEN_W-1:0]    dv_den_q [QUO_W+1];
  logic [QUO_W-1:0]    dv_low_q [QUO_W+1];
  logic [QUO_W-1:0]    dv_quo_q [QUO_W+1];
  logic [DEN_W-1:0]    dv_rem_d [QUO_W];
  logic [QUO_W-1:0]    dv_quo_d [QUO_W];

  logic                sq_vld_q [ROOT_W+1];
  logic                sq_has_q [ROOT_W+1];
  logic                sq_sat_q [ROOT_W+1];
  logic [QUO_W-1:0]    sq_x_q   [ROOT_W+1];
  logic [REM_W-1:0]    sq_rem_q [ROOT_W+1];
  logic [ROOT_W-1:0]   sq_root_q[ROOT_W+1];
  logic [REM_W-1:0]    sq_rem_d [ROOT_W];
  logic [ROOT_W-1:0]   sq_root_d[ROOT_W];

  logic                done_q, has_q;
  logic [ROOT_W-1:0]   dist_q;
  logic                sat;

  assign sat = (num_i[NUM_W-1:QUO_W] >= (NUM_W-QUO_W)'(den_i));

  always_comb begin
    logic [DEN_W:0] r2;
    logic [DEN_W:0] dn;
    for (int k = 0; k < QUO_W; k++) begin
      r2 = {dv_rem_q[k], dv_low_q[k][QUO_W-1]};
      dn = {1'b0, dv_den_q[k]};
      if (r2 >= dn) begin
        r2 = r2 - dn;
        dv_quo_d[k] = {dv_quo_q[k][QUO_W-2:0], 1'b1};
      end else begin
        dv_quo_d[k] = {dv_quo_q[k][QUO_W-2:0], 1'b0};
      end
      dv_rem_d[k] = r2[DEN_W-1:0];
    end
  end

  always_comb begin
    logic [REM_W+1:0] r2;
    logic [REM_W+1:0] trial;
    for (int j = 0; j < ROOT_W; j++) begin
      r2    = {sq_rem_q[j], sq_x_q[j][QUO_W-1 -: 2]};
      trial = {2'b00, sq_root_q[j], 2'b01};
      if (r2 >= trial) begin
        r2 = r2 - trial;
        sq_root_d[j] = {sq_root_q[j][ROOT_W-2:0], 1'b1};
      end else begin
        sq_root_d[j] = {sq_root_q[j][ROOT_W-2:0], 1'b0};
      end
      sq_rem_d[j] = r2[REM_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= QUO_W; k++) begin
        dv_vld_q[k] <= 1'b0;
      end
      for (int j = 0; j <= ROOT_W; j++) begin
        sq_vld_q[j] <= 1'b0;
      end
      done_q <= 1'b0;
    end else begin
      dv_vld_q[0] <= valid_i;
      for (int k = 0; k < QUO_W; k++) begin
        dv_vld_q[k+1] <= dv_vld_q[k];
      end
      sq_vld_q[0] <= dv_vld_q[QUO_W];
      for (int j = 0; j < ROOT_W; j++) begin
        sq_vld_q[j+1] <= sq_vld_q[j];
      end
      done_q <= sq_vld_q[ROOT_W];
    end
  end

  always_ff @(posedge clk_i) begin
    dv_has_q[0] <= has_i;
    dv_sat_q[0] <= sat;
    dv_rem_q[0] <= sat ? '0 : num_i[QUO_W+DEN_W-1:QUO_W];
    dv_den_q[0] <= den_i;
    dv_low_q[0] <= num_i[QUO_W-1:0];
    dv_quo_q[0] <= '0;
    for (int k = 0; k < QUO_W; k++) begin
      dv_has_q[k+1] <= dv_has_q[k];
      dv_sat_q[k+1] <= dv_sat_q[k];
      dv_rem_q[k+1] <= dv_rem_d[k];
      dv_den_q[k+1] <= dv_den_q[k];
      dv_low_q[k+1] <= dv_low_q[k] << 1;
      dv_quo_q[k+1] <= dv_quo_d[k];
    end

    sq_has_q[0]  <= dv_has_q[QUO_W];
    sq_sat_q[0]  <= dv_sat_q[QUO_W];
    sq_x_q[0]    <= dv_quo_q[QUO_W];
    sq_rem_q[0]  <= '0;
    sq_root_q[0] <= '0;
    for (int j = 0; j < ROOT_W; j++) begin
      sq_has_q[j+1]  <= sq_has_q[j];
      sq_sat_q[j+1]  <= sq_sat_q[j];
      sq_x_q[j+1]    <= sq_x_q[j] << 2;
      sq_rem_q[j+1]  <= sq_rem_d[j];
      sq_root_q[j+1] <= sq_root_d[j];
    end

    has_q <= sq_has_q[ROOT_W];
    if (!sq_has_q[ROOT_W]) begin
      dist_q <= '0;
    end else if (sq_sat_q[ROOT_W]) begin
      dist_q <= '1;
    end else begin
      dist_q <= sq_root_q[ROOT_W];
    end
  end

  assign done_o = done_q;
  assign has_o  = has_q;
  assign dist_o = dist_q;

endmodule

`default_nettype wire

// ----- design/focus_distance_to_axis_or_apex_top.sv -----
// ----------------------------------------------------------------------------
// focus_distance_to_axis_or_apex_top
// Distance from a configured focus point to a cylinder axis or a cone apex.
// ----------------------------------------------------------------------------
// A command word is taken on each rising edge where start is high and busy
// is low. It carries the shape kind and two points in signed Q16.16. The
// focus point is set through the configuration channel (index 0 to 2 for x,
// y and z), which is always ready; write it only while no command is in
// flight.
// Every command gives exactly one result: done_o is high for one cycle with
// has_distance_o and distance_o (unsigned Q16.16, truncated, saturated).
// Other shape kinds give has_distance_o low and a zero distance.
// A new command can be taken every cycle. The result strobe follows the
// accepting edge through the queue, the product and sum stages, the
// bit-per-stage quotient with its load stage, the bit-per-stage square
// root with its load stage, and the result register.
// The front queue drains every cycle, so busy stays low.
// Reset clears the focus to the origin and drops every command in flight.
// The receiver cannot stall; results are shown once and not held.
// ----------------------------------------------------------------------------
`default_nettype none

module focus_distance_to_axis_or_apex_top import fdaa_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]       cfg_index_i,
  input  logic signed [COORD_W-1:0]  cfg_data_i,
  input  logic [CMD_W-1:0]           command_i,
  input  logic signed [COORD_W-1:0]  first_x_i,
  input  logic signed [COORD_W-1:0]  first_y_i,
  input  logic signed [COORD_W-1:0]  first_z_i,
  input  logic signed [COORD_W-1:0]  second_x_i,
  input  logic signed [COORD_W-1:0]  second_y_i,
  input  logic signed [COORD_W-1:0]  second_z_i,
  output logic                       done_o,
  output logic                       has_distance_o,
  output logic [ROOT_W-1:0]          distance_o
);

  item_t              front_item, queue_item;
  logic               q_full, q_empty, push;
  logic               calc_vld, calc_has;
  logic [NUM_W-1:0]   calc_num;
  logic [DEN_W-1:0]   calc_den;

  assign cfg_ready_o = 1'b1;
  assign busy        = q_full;
  assign push        = start && !q_full;

  fdaa_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (command_i),
    .ax_i        (first_x_i),
    .ay_i        (first_y_i),
    .az_i        (first_z_i),
    .bx_i        (second_x_i),
    .by_i        (second_y_i),
    .bz_i        (second_z_i),
    .item_o      (front_item)
  );

  fdaa_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_item),
    .pop_i   (!q_empty),
    .data_o  (queue_item),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  fdaa_calc u_calc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (!q_empty),
    .item_i  (queue_item),
    .valid_o (calc_vld),
    .has_o   (calc_has),
    .num_o   (calc_num),
    .den_o   (calc_den)
  );

  fdaa_root u_root (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (calc_vld),
    .has_i   (calc_has),
    .num_i   (calc_num),
    .den_i   (calc_den),
    .done_o  (done_o),
    .has_o   (has_distance_o),
    .dist_o  (distance_o)
  );

`ifndef SYNTHESIS
  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy)
    else $error("front queue filled up");
  a_accept_queued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |=> !q_empty)
    else $error("accepted word missing from queue");
  a_no_dist_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !has_distance_o |-> distance_o == '0)
    else $error("nonzero distance without a distance");
`endif

endmodule

`default_nettype wire
